@@ rtl/cdq_pkg.sv @@
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared types and constants for the circular double-ended queue.
// ----------------------------------------------------------------------------
package cdq_pkg;

  localparam int unsigned DEPTH = 8;
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned DATA_W = 32;

  typedef enum logic [1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_REAR  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_REAR   = 2'd3
  } cdq_op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } cdq_status_e;

  typedef struct packed {
    cdq_op_e                    operation;
    logic signed [DATA_W-1:0]   push_value;
  } cdq_req_t;

  typedef struct packed {
    cdq_status_e                status;
    logic signed [DATA_W-1:0]   popped_value;
  } cdq_rsp_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;   // take the request and update state
    logic emit;   // result is on the output this cycle
  } cdq_cmd_t;

endpackage

@@ rtl/cdq_ctrl.sv @@
// ----------------------------------------------------------------------------
// cdq_ctrl
// Sequencer: accepts a request, then presents its result for one cycle.
// ----------------------------------------------------------------------------
module cdq_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  output logic            busy_o,
  output cdq_pkg::cdq_cmd_t cmd_o
);
  import cdq_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_RESP
  } state_e;

  state_e state_q;
  logic   busy_q;
  logic   emit_q;
  logic   load;

  assign load = start_i & ~busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      busy_q  <= 1'b0;
      emit_q  <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (load) begin
            state_q <= S_RESP;
            busy_q  <= 1'b1;
            emit_q  <= 1'b1;
          end
        end
        S_RESP: begin
          state_q <= S_IDLE;
          busy_q  <= 1'b0;
          emit_q  <= 1'b0;
        end
        default: begin
          state_q <= S_IDLE;
          busy_q  <= 1'b0;
          emit_q  <= 1'b0;
        end
      endcase
    end
  end

  assign busy_o     = busy_q;
  assign cmd_o.load = load;
  assign cmd_o.emit = emit_q;

endmodule

@@ rtl/cdq_datapath.sv @@
// ----------------------------------------------------------------------------
// cdq_datapath
// Entry store, front and rear pointers, empty flag and result registers.
// ----------------------------------------------------------------------------
module cdq_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cdq_pkg::cdq_cmd_t cmd_i,
  input  cdq_pkg::cdq_req_t req_i,
  output logic              valid_o,
  output cdq_pkg::cdq_rsp_t rsp_o
);
  import cdq_pkg::*;

  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [PTR_W-1:0] ZERO = '0;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  logic [PTR_W-1:0] front_q, front_d;
  logic [PTR_W-1:0] rear_q, rear_d;
  logic             empty_q, empty_d;
  cdq_status_e      status_q, status_d;
  logic             pop_ok_q, pop_ok_d;

  logic             full;
  logic             we;
  logic [PTR_W-1:0] waddr;
  logic             re;
  logic [PTR_W-1:0] raddr;
  logic [PTR_W-1:0] front_inc, front_dec, rear_inc, rear_dec;

  assign front_inc = (front_q == LAST) ? ZERO : front_q + 1'b1;
  assign front_dec = (front_q == ZERO) ? LAST : front_q - 1'b1;
  assign rear_inc  = (rear_q == LAST) ? ZERO : rear_q + 1'b1;
  assign rear_dec  = (rear_q == ZERO) ? LAST : rear_q - 1'b1;
  assign full      = ~empty_q & (rear_inc == front_q);

  always_comb begin
    front_d  = front_q;
    rear_d   = rear_q;
    empty_d  = empty_q;
    status_d = ST_OK;
    pop_ok_d = 1'b0;
    we       = 1'b0;
    waddr    = ZERO;
    re       = 1'b0;
    raddr    = front_q;
    unique case (req_i.operation)
      OP_PUSH_FRONT, OP_PUSH_REAR: begin
        if (full) begin
          status_d = ST_FULL;
        end else if (empty_q) begin
          empty_d = 1'b0;
          front_d = ZERO;
          rear_d  = ZERO;
          we      = 1'b1;
          waddr   = ZERO;
        end else if (req_i.operation == OP_PUSH_FRONT) begin
          front_d = front_dec;
          we      = 1'b1;
          waddr   = front_dec;
        end else begin
          rear_d = rear_inc;
          we     = 1'b1;
          waddr  = rear_inc;
        end
      end
      OP_POP_FRONT, OP_POP_REAR: begin
        if (empty_q) begin
          status_d = ST_EMPTY;
        end else begin
          pop_ok_d = 1'b1;
          re       = 1'b1;
          raddr    = (req_i.operation == OP_POP_FRONT) ? front_q : rear_q;
          // last entry gone: back to the reset arrangement
          if (front_q == rear_q) begin
            empty_d = 1'b1;
            front_d = ZERO;
            rear_d  = ZERO;
          end else if (req_i.operation == OP_POP_FRONT) begin
            front_d = front_inc;
          end else begin
            rear_d = rear_dec;
          end
        end
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q  <= '0;
      rear_q   <= '0;
      empty_q  <= 1'b1;
      status_q <= ST_OK;
      pop_ok_q <= 1'b0;
    end else if (cmd_i.load) begin
      front_q  <= front_d;
      rear_q   <= rear_d;
      empty_q  <= empty_d;
      status_q <= status_d;
      pop_ok_q <= pop_ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && we) begin
      mem[waddr] <= req_i.push_value;
    end
    if (cmd_i.load && re) begin
      rdata_q <= mem[raddr];
    end
  end

  assign valid_o            = cmd_i.emit;
  assign rsp_o.status       = status_q;
  assign rsp_o.popped_value = pop_ok_q ? signed'(rdata_q) : '0;

endmodule

@@ rtl/circular_deque_core.sv @@
// ----------------------------------------------------------------------------
// circular_deque_core
// Fixed-size circular double-ended queue with push/pop at either end.
// ----------------------------------------------------------------------------
// usage
//   a request (req_i: operation, push_value) is taken on a rising edge where
//   start is high and busy is low. busy rises for one cycle after that.
//   the result (rsp_o: status, popped_value) is presented for exactly one
//   cycle with valid_o high, the cycle right after the request was taken.
//   the store read for a pop is registered, and the sequencer holds off the
//   next request while the result is shown, so requests never overlap.
//   status ok for a push that fitted or a pop that found data; full when a
//   push finds no room, empty when a pop finds nothing, with state unchanged.
//   popped_value is zero unless a pop succeeded.
//   reset empties the queue and sets both pointers to zero; store contents
//   are not cleared. the receiver cannot stall, so results are never held.
// ----------------------------------------------------------------------------
module circular_deque_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  cdq_pkg::cdq_req_t req_i,
  output logic              valid_o,
  output cdq_pkg::cdq_rsp_t rsp_o
);
  import cdq_pkg::*;

  cdq_cmd_t cmd;

  cdq_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .cmd_o   (cmd)
  );

  cdq_datapath u_datapath (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .req_i   (req_i),
    .valid_o (valid_o),
    .rsp_o   (rsp_o)
  );

endmodule
